>>> hdl/crcfc_pkg.sv
package crcfc_pkg;

  // frame layout and bounds
  localparam longint unsigned MAX_FRAME_BYTES = 64'd65536;
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 64'd1);
  localparam int HDR_BYTES = 24;
  localparam int TRAILER_BYTES = 4;
  localparam int MIN_FRAME_BYTES = HDR_BYTES + TRAILER_BYTES;
  localparam int MAGIC_BYTES = 4;
  localparam int VERSION_POS = 4;
  // wide enough for header + 32-bit length + trailer and for any byte count
  localparam int EXP_W = 34;

  localparam logic [7:0]  FRAME_VERSION = 8'h01;
  localparam logic [31:0] MAGIC_WORD = 32'h4C48_5243;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 168;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_SHORT    = 3'd1,
    ST_BAD_MAGIC    = 3'd2,
    ST_BAD_VERSION  = 3'd3,
    ST_LEN_MISMATCH = 3'd4,
    ST_CRC_MISMATCH = 3'd5
  } status_t;

  // one result item
  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    status_t     status;
    logic [7:0]  msg_type;
    logic [15:0] frame_flags;
    logic [31:0] sequence_number;
    logic [63:0] timestamp;
    logic [31:0] payload_size;
  } res_t;

  // the up to two result items caused by one input item
  typedef struct packed {
    logic pay_valid;
    logic stat_valid;
    res_t pay;
    res_t stat;
  } step_res_t;

  // expected magic byte at header position idx
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = MAGIC_WORD[7:0];
      2'd1: b = MAGIC_WORD[15:8];
      2'd2: b = MAGIC_WORD[23:16];
      default: b = MAGIC_WORD[31:24];
    endcase
    return b;
  endfunction

  // reflected crc-32, one byte, unrolled
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

>>> hdl/crcfc_frame.sv
module crcfc_frame (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  logic                  end_of_frame,
  output crcfc_pkg::step_res_t  res
);
  import crcfc_pkg::*;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             count_overflow, count_overflow_next;
  logic             magic_bad, magic_bad_next;
  logic             version_bad, version_bad_next;
  logic [31:0]      running_crc, running_crc_next;
  logic [31:0]      received_crc, received_crc_next;
  logic [7:0]       hdr [HDR_BYTES];

  logic             stored;
  logic             in_hdr;
  logic             is_payload;
  logic [31:0]      hdr_len;
  logic [EXP_W-1:0] pay_off;
  logic [EXP_W-1:0] expect_len;
  status_t          st;

  assign hdr_len = {hdr[23], hdr[22], hdr[21], hdr[20]};

  // per-byte frame state update
  always_comb begin
    stored = !count_overflow && (byte_count < CNT_W'(MAX_FRAME_BYTES));
    byte_count_next = stored ? byte_count + CNT_W'(1) : byte_count;
    count_overflow_next = count_overflow | ~stored;
    // byte leaving the four-byte trailer delay line joins the crc
    if (count_overflow || (byte_count >= CNT_W'(TRAILER_BYTES))) begin
      running_crc_next = crc_byte(running_crc, received_crc[7:0]);
    end else begin
      running_crc_next = running_crc;
    end
    received_crc_next = {rx_byte, received_crc[31:8]};
    in_hdr = stored && (byte_count < CNT_W'(HDR_BYTES));
    magic_bad_next = magic_bad;
    if (in_hdr && (byte_count < CNT_W'(MAGIC_BYTES)) &&
        (rx_byte != magic_byte(byte_count[1:0]))) begin
      magic_bad_next = 1'b1;
    end
    version_bad_next = version_bad;
    if (in_hdr && (byte_count == CNT_W'(VERSION_POS)) && (rx_byte != FRAME_VERSION)) begin
      version_bad_next = 1'b1;
    end
  end

  // payload position test
  always_comb begin
    pay_off = EXP_W'(byte_count) - EXP_W'(HDR_BYTES);
    is_payload = stored && !in_hdr && (pay_off < EXP_W'(hdr_len));
  end

  // status in priority order, on the state after this byte
  always_comb begin
    expect_len = EXP_W'(HDR_BYTES) + EXP_W'(hdr_len) + EXP_W'(TRAILER_BYTES);
    if (!count_overflow_next && (byte_count_next < CNT_W'(MIN_FRAME_BYTES))) begin
      st = ST_TOO_SHORT;
    end else if (magic_bad_next) begin
      st = ST_BAD_MAGIC;
    end else if (version_bad_next) begin
      st = ST_BAD_VERSION;
    end else if (count_overflow_next || (EXP_W'(byte_count_next) != expect_len)) begin
      st = ST_LEN_MISMATCH;
    end else if (~running_crc_next != received_crc_next) begin
      st = ST_CRC_MISMATCH;
    end else begin
      st = ST_OK;
    end
  end

  // result items for this byte
  always_comb begin
    res = '0;
    res.pay_valid = step && is_payload;
    res.stat_valid = step && end_of_frame;
    res.pay.item_kind = 1'b0;
    res.pay.payload_byte = rx_byte;
    res.pay.status = ST_OK;
    res.stat.item_kind = 1'b1;
    res.stat.status = st;
    if (st == ST_OK) begin
      res.stat.msg_type = hdr[5];
      res.stat.frame_flags = {hdr[7], hdr[6]};
      res.stat.sequence_number = {hdr[11], hdr[10], hdr[9], hdr[8]};
      res.stat.timestamp = {hdr[19], hdr[18], hdr[17], hdr[16],
                            hdr[15], hdr[14], hdr[13], hdr[12]};
      res.stat.payload_size = hdr_len;
    end
  end

  // frame state, back to reset after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      count_overflow <= 1'b0;
      magic_bad <= 1'b0;
      version_bad <= 1'b0;
      running_crc <= CRC_INIT;
      received_crc <= '0;
    end else if (step) begin
      if (end_of_frame) begin
        byte_count <= '0;
        count_overflow <= 1'b0;
        magic_bad <= 1'b0;
        version_bad <= 1'b0;
        running_crc <= CRC_INIT;
        received_crc <= '0;
      end else begin
        byte_count <= byte_count_next;
        count_overflow <= count_overflow_next;
        magic_bad <= magic_bad_next;
        version_bad <= version_bad_next;
        running_crc <= running_crc_next;
        received_crc <= received_crc_next;
      end
    end
  end

  // header byte store, only read once every position has been written
  always_ff @(posedge clk) begin
    if (step && in_hdr) begin
      hdr[byte_count[4:0]] <= rx_byte;
    end
  end

endmodule

>>> hdl/crcfc_outq.sv
module crcfc_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  crcfc_pkg::step_res_t  push,
  output logic                  can_take,
  output logic                  out_valid,
  input  logic                  out_ready,
  output crcfc_pkg::res_t       out_res
);
  import crcfc_pkg::*;

  logic pend_valid;
  res_t pend_res;
  logic pop;

  // a new step needs the spare slot free and the output register free or leaving
  assign pop = out_valid && out_ready;
  assign can_take = !pend_valid && (!out_valid || out_ready);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else if (pend_valid) begin
      if (pop) begin
        pend_valid <= 1'b0;
      end
    end else if (push.pay_valid || push.stat_valid) begin
      out_valid <= 1'b1;
      pend_valid <= push.pay_valid && push.stat_valid;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // payload: payload byte first, status waits in the spare slot
  always_ff @(posedge clk) begin
    if (pend_valid) begin
      if (pop) begin
        out_res <= pend_res;
      end
    end else if (push.pay_valid) begin
      out_res <= push.pay;
      pend_res <= push.stat;
    end else if (push.stat_valid) begin
      out_res <= push.stat;
    end
  end

endmodule

>>> hdl/crc_frame_checker_unit.sv
// Frame checker: takes a frame one byte per item on s_axis (tlast on the final
// byte), checks the 24-byte little-endian header, the length and the reflected
// CRC-32 trailer, passes payload bytes out as they arrive (m_axis tlast low)
// and ends each frame with one status item (m_axis tlast high) that carries
// the header fields when the status is ok. A byte is taken every cycle unless
// m_axis back-pressure holds it; input also waits when the final byte is also
// a payload byte, since the two output items it causes leave through the
// single output register one after the other. An input item reaches its first
// output item through the input register, then the result register. All frame
// state returns to its reset values after the final byte.
module crc_frame_checker_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] rx_byte
  input  logic [crcfc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] payload_byte, [10:8] status, [18:11] msg_type, [34:19] frame_flags,
  // [66:35] sequence_number, [130:67] timestamp, [162:131] payload_size, rest zero
  output logic [crcfc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import crcfc_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       can_take;
  logic       step;
  step_res_t  step_res;
  res_t       out_res;

  assign step = in_valid && can_take;
  assign s_axis_tready = !in_valid || can_take;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata[7:0];
      in_last <= s_axis_tlast;
    end
  end

  crcfc_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .rx_byte      (in_byte),
    .end_of_frame (in_last),
    .res          (step_res)
  );

  crcfc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (step_res),
    .can_take  (can_take),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // output packing
  assign m_axis_tlast = out_res.item_kind;
  assign m_axis_tdata = {5'd0, out_res.payload_size, out_res.timestamp,
                         out_res.sequence_number, out_res.frame_flags,
                         out_res.msg_type, out_res.status, out_res.payload_byte};

endmodule
